### src/ffca_pkg.sv
package ffca_pkg;

    localparam int NUM_CHUNKS_DEF  = 256;
    localparam int CHUNK_BYTES_DEF = 64;

    localparam int REQ_BYTES_W  = 32;
    localparam int CHUNK_IDX_W  = 8;
    localparam int STATUS_W     = 2;
    localparam int DATA_CHUNK_W = 8;

    // tdata: req_bytes, chunk_index
    localparam int S_TDATA_W = 40;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOMEM = 2'd1,
        ST_INVAL = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    // write strobes and entry bits for the chunk table
    typedef struct packed {
        logic we;
        logic rl_we;
        logic hdr;
        logic taken;
    } t_mem_ctl;

endpackage

### src/ffca_chunk_mem.sv
module ffca_chunk_mem #(
    parameter int NUM_CHUNKS = ffca_pkg::NUM_CHUNKS_DEF,
    parameter int AW         = $clog2(NUM_CHUNKS),
    parameter int RW         = $clog2(NUM_CHUNKS + 1)
) (
    input  logic              i_clk,
    input  ffca_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [RW-1:0]     i_rl_data,
    output logic              o_hdr,
    output logic              o_taken,
    output logic [RW-1:0]     o_rl
);
    import ffca_pkg::*;

    logic [1:0]    r_meta_mem [NUM_CHUNKS];
    logic [RW-1:0] r_rl_mem   [NUM_CHUNKS];
    logic [1:0]    r_meta_q;
    logic [RW-1:0] r_rl_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_meta_mem[i_wr_addr] <= {i_ctl.hdr, i_ctl.taken};
        end
        r_meta_q <= r_meta_mem[i_rd_addr];
    end

    // run length: written only together with a header mark
    always_ff @(posedge i_clk) begin
        if (i_ctl.rl_we) begin
            r_rl_mem[i_wr_addr] <= i_rl_data;
        end
        r_rl_q <= r_rl_mem[i_rd_addr];
    end

    assign o_hdr   = r_meta_q[1];
    assign o_taken = r_meta_q[0];
    assign o_rl    = r_rl_q;

endmodule

### src/ffca_fit_unit.sv
module ffca_fit_unit #(
    parameter int NUM_CHUNKS  = ffca_pkg::NUM_CHUNKS_DEF,
    parameter int CHUNK_BYTES = ffca_pkg::CHUNK_BYTES_DEF,
    parameter int RW          = $clog2(NUM_CHUNKS + 1),
    parameter int CAPW        = $clog2(NUM_CHUNKS * CHUNK_BYTES + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clr,
    input  logic            i_step,
    input  logic            i_taken,
    input  logic [CAPW:0]   i_thresh,
    output logic            o_hit,
    output logic [RW-1:0]   o_run
);
    import ffca_pkg::*;

    logic [CAPW:0]  r_cap;
    logic [CAPW:0]  n_cap;
    logic [RW-1:0]  r_run;
    logic [RW-1:0]  n_run;

    // r_cap tracks run * CHUNK_BYTES; the run fits once it covers bytes plus the header
    always_comb begin
        if (i_taken) begin
            n_cap = '0;
            n_run = '0;
        end else begin
            n_cap = r_cap + (CAPW+1)'(CHUNK_BYTES);
            n_run = r_run + RW'(1);
        end
    end

    assign o_hit = !i_taken && (n_cap >= i_thresh);
    assign o_run = n_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_cap <= '0;
            r_run <= '0;
        end else if (i_step) begin
            r_cap <= n_cap;
            r_run <= n_run;
        end
    end

endmodule

### src/ffca_ctrl.sv
module ffca_ctrl #(
    parameter int NUM_CHUNKS  = ffca_pkg::NUM_CHUNKS_DEF,
    parameter int CHUNK_BYTES = ffca_pkg::CHUNK_BYTES_DEF,
    parameter int AW          = $clog2(NUM_CHUNKS),
    parameter int RW          = $clog2(NUM_CHUNKS + 1),
    parameter int CAPW        = $clog2(NUM_CHUNKS * CHUNK_BYTES + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  ffca_pkg::t_func                   i_func,
    input  logic [ffca_pkg::REQ_BYTES_W-1:0]  i_req_bytes,
    input  logic [ffca_pkg::CHUNK_IDX_W-1:0]  i_chunk_index,
    input  logic                              i_slot_free,
    output logic                              o_done,
    output ffca_pkg::t_status                 o_status,
    output logic [ffca_pkg::DATA_CHUNK_W-1:0] o_data_chunk,
    output ffca_pkg::t_mem_ctl                o_mem_ctl,
    output logic [AW-1:0]                     o_rd_addr,
    output logic [AW-1:0]                     o_wr_addr,
    output logic [RW-1:0]                     o_rl_data,
    input  logic                              i_hdr,
    input  logic                              i_taken,
    input  logic [RW-1:0]                     i_rl,
    output logic                              o_fit_clr,
    output logic                              o_fit_step,
    output logic [CAPW:0]                     o_thresh,
    input  logic                              i_fit_hit,
    input  logic [RW-1:0]                     i_fit_run
);
    import ffca_pkg::*;

    localparam int           POOL  = NUM_CHUNKS * CHUNK_BYTES;
    localparam logic [AW-1:0] LAST = AW'(NUM_CHUNKS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MARK,
        S_HDR_CHK,
        S_RELEASE,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    t_func                   r_func;
    logic [REQ_BYTES_W-1:0]  r_bytes;
    logic [CHUNK_IDX_W-1:0]  r_idx;
    logic [CAPW:0]           r_thresh, n_thresh;
    logic [AW-1:0]           r_k, n_k;
    logic [AW-1:0]           r_rd_addr, n_rd_addr;
    logic [AW-1:0]           r_chk, n_chk;
    logic [AW-1:0]           r_start, n_start;
    logic [RW-1:0]           r_left, n_left;
    t_status                 r_status, n_status;
    logic [DATA_CHUNK_W-1:0] r_data, n_data;
    logic [CHUNK_IDX_W-1:0]  hdr_idx;
    logic [AW:0]             fit_start;
    logic [AW:0]             start_p1;

    assign hdr_idx   = r_idx - CHUNK_IDX_W'(1);
    assign fit_start = {1'b0, r_chk} + (AW+1)'(1) - (AW+1)'(i_fit_run);
    assign start_p1  = {1'b0, r_start} + (AW+1)'(1);

    always_comb begin
        n_state   = r_state;
        n_thresh  = r_thresh;
        n_k       = r_k;
        n_rd_addr = r_rd_addr;
        n_chk     = r_chk;
        n_start   = r_start;
        n_left    = r_left;
        n_status  = r_status;
        n_data    = r_data;
        o_mem_ctl = '0;
        o_wr_addr = r_k;
        o_rl_data = r_left;
        o_rd_addr = r_rd_addr;
        o_fit_clr = 1'b0;
        o_fit_step = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_mem_ctl.we = 1'b1;
                n_k = r_k + AW'(1);
                if (r_k == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_data = '0;
                if (r_func == FUNC_ALLOC) begin
                    if (r_bytes == '0) begin
                        n_status = ST_ZERO;
                        n_state  = S_DONE;
                    end else if (r_bytes > REQ_BYTES_W'(POOL)) begin
                        n_status = ST_NOMEM;
                        n_state  = S_DONE;
                    end else begin
                        n_thresh  = (CAPW+1)'(r_bytes) + (CAPW+1)'(CHUNK_BYTES);
                        o_fit_clr = 1'b1;
                        o_rd_addr = '0;
                        n_rd_addr = AW'(1);
                        n_chk     = '0;
                        n_state   = S_SCAN;
                    end
                end else begin
                    if (r_idx == '0) begin
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else if (32'(hdr_idx) >= 32'(NUM_CHUNKS)) begin
                        n_status = ST_INVAL;
                        n_state  = S_DONE;
                    end else begin
                        o_rd_addr = AW'(hdr_idx);
                        n_k       = AW'(hdr_idx);
                        n_state   = S_HDR_CHK;
                    end
                end
            end
            S_SCAN: begin
                // read of r_rd_addr in flight, data for r_chk arriving
                o_fit_step = 1'b1;
                n_rd_addr  = r_rd_addr + AW'(1);
                n_chk      = r_chk + AW'(1);
                if (i_fit_hit) begin
                    n_start = fit_start[AW-1:0];
                    n_k     = fit_start[AW-1:0];
                    n_left  = i_fit_run;
                    n_state = S_MARK;
                end else if (r_chk == LAST) begin
                    n_status = ST_NOMEM;
                    n_state  = S_DONE;
                end
            end
            S_MARK: begin
                o_mem_ctl.we    = 1'b1;
                o_mem_ctl.taken = 1'b1;
                o_mem_ctl.hdr   = (r_k == r_start);
                o_mem_ctl.rl_we = (r_k == r_start);
                n_k    = r_k + AW'(1);
                n_left = r_left - RW'(1);
                if (r_left <= RW'(1)) begin
                    n_status = ST_OK;
                    n_data   = DATA_CHUNK_W'(start_p1);
                    n_state  = S_DONE;
                end
            end
            S_HDR_CHK: begin
                if (!i_hdr) begin
                    n_status = ST_INVAL;
                    n_state  = S_DONE;
                end else begin
                    n_left  = i_rl;
                    n_state = S_RELEASE;
                end
            end
            S_RELEASE: begin
                o_mem_ctl.we = 1'b1;
                n_k    = r_k + AW'(1);
                n_left = r_left - RW'(1);
                if (r_left <= RW'(1) || r_k == LAST) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_k       <= '0;
            r_rd_addr <= '0;
            r_chk     <= '0;
            r_left    <= '0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_rd_addr <= n_rd_addr;
            r_chk     <= n_chk;
            r_left    <= n_left;
        end
        if (r_state == S_IDLE && i_valid) begin
            r_func  <= i_func;
            r_bytes <= i_req_bytes;
            r_idx   <= i_chunk_index;
        end
        r_thresh <= n_thresh;
        r_start  <= n_start;
        r_status <= n_status;
        r_data   <= n_data;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_done       = (r_state == S_DONE) && i_slot_free;
    assign o_status     = r_status;
    assign o_data_chunk = r_data;
    assign o_thresh     = r_thresh;

endmodule

### src/first_fit_chunk_allocator.sv
// Channel   Dir  Handshake                     Payload (low bit up)
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: req_bytes[31:0], chunk_index[39:32]
//                                              tuser: func
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: data_chunk[7:0]; tuser: status[1:0]
//
// One request at a time; each beat is taken in the idle state. Allocate: a check, a
// first-fit scan of up to NUM_CHUNKS chunks, then marking of the run's chunks; the
// single add/compare unit and the one-read-port chunk table set this order. Free: a check,
// a header read, then release of the run's chunks; a null or out-of-pool index ends after
// the check. After reset a clearing pass over all NUM_CHUNKS chunks runs with
// s_axis_tready low. A result waits in the output register while the next beat is taken.
module first_fit_chunk_allocator #(
    parameter int NUM_CHUNKS  = ffca_pkg::NUM_CHUNKS_DEF,
    parameter int CHUNK_BYTES = ffca_pkg::CHUNK_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ffca_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // req_bytes, chunk_index
    input  logic                              s_axis_tuser,  // func
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ffca_pkg::DATA_CHUNK_W-1:0] m_axis_tdata,  // data_chunk
    output logic [ffca_pkg::STATUS_W-1:0]     m_axis_tuser   // status
);
    import ffca_pkg::*;

    localparam int AW   = $clog2(NUM_CHUNKS);
    localparam int RW   = $clog2(NUM_CHUNKS + 1);
    localparam int CAPW = $clog2(NUM_CHUNKS * CHUNK_BYTES + 1);

    t_mem_ctl                mem_ctl;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic [RW-1:0]           rl_data;
    logic                    mem_hdr;
    logic                    mem_taken;
    logic [RW-1:0]           mem_rl;
    logic                    fit_clr;
    logic                    fit_step;
    logic [CAPW:0]           fit_thresh;
    logic                    fit_hit;
    logic [RW-1:0]           fit_run;
    logic                    slot_free;
    logic                    done;
    t_status                 done_status;
    logic [DATA_CHUNK_W-1:0] done_data;
    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [DATA_CHUNK_W-1:0] r_out_data;

    assign slot_free = !r_out_valid || m_axis_tready;

    ffca_ctrl #(
        .NUM_CHUNKS  (NUM_CHUNKS),
        .CHUNK_BYTES (CHUNK_BYTES),
        .AW          (AW),
        .RW          (RW),
        .CAPW        (CAPW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_func        (t_func'(s_axis_tuser)),
        .i_req_bytes   (s_axis_tdata[REQ_BYTES_W-1:0]),
        .i_chunk_index (s_axis_tdata[REQ_BYTES_W +: CHUNK_IDX_W]),
        .i_slot_free   (slot_free),
        .o_done        (done),
        .o_status      (done_status),
        .o_data_chunk  (done_data),
        .o_mem_ctl     (mem_ctl),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_rl_data     (rl_data),
        .i_hdr         (mem_hdr),
        .i_taken       (mem_taken),
        .i_rl          (mem_rl),
        .o_fit_clr     (fit_clr),
        .o_fit_step    (fit_step),
        .o_thresh      (fit_thresh),
        .i_fit_hit     (fit_hit),
        .i_fit_run     (fit_run)
    );

    ffca_chunk_mem #(
        .NUM_CHUNKS (NUM_CHUNKS),
        .AW         (AW),
        .RW         (RW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_rl_data (rl_data),
        .o_hdr     (mem_hdr),
        .o_taken   (mem_taken),
        .o_rl      (mem_rl)
    );

    ffca_fit_unit #(
        .NUM_CHUNKS  (NUM_CHUNKS),
        .CHUNK_BYTES (CHUNK_BYTES),
        .RW          (RW),
        .CAPW        (CAPW)
    ) u_fit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (fit_clr),
        .i_step   (fit_step),
        .i_taken  (mem_taken),
        .i_thresh (fit_thresh),
        .o_hit    (fit_hit),
        .o_run    (fit_run)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (done) begin
            r_out_status <= done_status;
            r_out_data   <= done_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

endmodule

### test/ffca_result_check.sv
`timescale 1ns / 100ps

module ffca_result_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [ffca_pkg::S_TDATA_W-1:0]    i_s_tdata,   // req_bytes, chunk_index
    input  logic                              i_s_tuser,   // func
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [ffca_pkg::DATA_CHUNK_W-1:0] i_m_tdata,   // data_chunk
    input  logic [ffca_pkg::STATUS_W-1:0]     i_m_tuser,   // status
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_granted,
    output int                                o_released,
    output int                                o_nomem,
    output int                                o_inval,
    output int                                o_zero
);
    import ffca_pkg::*;

    localparam int POOL_CHUNKS = NUM_CHUNKS_DEF;
    localparam int UNIT_BYTES  = CHUNK_BYTES_DEF;
    localparam int POOL_BYTES  = POOL_CHUNKS * UNIT_BYTES;

    typedef struct packed {
        t_status                 status;
        logic [DATA_CHUNK_W-1:0] chunk;
    } t_outcome;

    bit       chunk_busy [POOL_CHUNKS];
    bit       head_mark  [POOL_CHUNKS];
    bit [8:0] span_len   [POOL_CHUNKS];

    t_outcome pending_results[$];

    function automatic t_outcome predict_alloc(input logic [REQ_BYTES_W-1:0] nbytes);
        t_outcome res;
        int       need;
        int       run;
        int       start;
        bit       found;
        res.status = ST_OK;
        res.chunk  = '0;
        found      = 1'b0;
        run        = 0;
        start      = 0;
        if (nbytes == 0) begin
            res.status = ST_ZERO;
            return res;
        end
        if (nbytes > 32'(POOL_BYTES)) begin
            res.status = ST_NOMEM;
            return res;
        end
        // data chunks rounded up, plus the header chunk
        need = int'(nbytes) / UNIT_BYTES + ((int'(nbytes) % UNIT_BYTES) != 0 ? 1 : 0) + 1;
        for (int i = 0; i < POOL_CHUNKS && !found; i++) begin
            if (chunk_busy[i])
                run = 0;
            else
                run++;
            if (run == need) begin
                start = i + 1 - need;
                found = 1'b1;
            end
        end
        if (!found) begin
            res.status = ST_NOMEM;
            return res;
        end
        for (int k = 0; k < need; k++)
            chunk_busy[start + k] = 1'b1;
        head_mark[start] = 1'b1;
        span_len[start]  = 9'(need);
        res.chunk        = DATA_CHUNK_W'(start + 1);
        return res;
    endfunction

    function automatic t_outcome predict_free(input logic [CHUNK_IDX_W-1:0] idx);
        t_outcome res;
        int       hdr;
        int       stop;
        res.status = ST_OK;
        res.chunk  = '0;
        if (idx == 0)
            return res;
        hdr = int'(idx) - 1;
        if (hdr >= POOL_CHUNKS || !head_mark[hdr]) begin
            res.status = ST_INVAL;
            return res;
        end
        stop = hdr + int'(span_len[hdr]);
        if (stop > POOL_CHUNKS)
            stop = POOL_CHUNKS;
        for (int k = hdr; k < stop; k++)
            chunk_busy[k] = 1'b0;
        head_mark[hdr] = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            for (int i = 0; i < POOL_CHUNKS; i++) begin
                chunk_busy[i] = 1'b0;
                head_mark[i]  = 1'b0;
                span_len[i]   = '0;
            end
            pending_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no request waiting: status %0d data_chunk %0d",
                           i_m_tuser, i_m_tdata);
                    o_errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_m_tuser);
                        o_errors++;
                    end
                    if (i_m_tdata !== want.chunk) begin
                        $error("data_chunk: expected %0d, actual %0d", want.chunk, i_m_tdata);
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (t_func'(i_s_tuser) == FUNC_ALLOC)
                    got = predict_alloc(i_s_tdata[REQ_BYTES_W-1:0]);
                else
                    got = predict_free(i_s_tdata[REQ_BYTES_W +: CHUNK_IDX_W]);
                case (got.status)
                    ST_OK: begin
                        if (t_func'(i_s_tuser) == FUNC_ALLOC)
                            o_granted++;
                        else
                            o_released++;
                    end
                    ST_NOMEM: o_nomem++;
                    ST_INVAL: o_inval++;
                    ST_ZERO:  o_zero++;
                    default: ;
                endcase
                pending_results.push_back(got);
            end
            o_pending = pending_results.size();
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ffca_pkg::*;

    localparam int RANDOM_ITEMS = 700;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_TDATA_W-1:0]    s_axis_tdata = '0;   // req_bytes, chunk_index
    logic                    s_axis_tuser = 1'b0; // func
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [DATA_CHUNK_W-1:0] m_axis_tdata;        // data_chunk
    logic [STATUS_W-1:0]     m_axis_tuser;        // status

    int err_count;
    int pending;
    int granted;
    int released;
    int nomem_cnt;
    int inval_cnt;
    int zero_cnt;

    bit steady = 1'b0;

    logic [CHUNK_IDX_W-1:0] live_handles[$];
    logic [CHUNK_IDX_W-1:0] freed_handles[$];

    first_fit_chunk_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ffca_result_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .o_errors   (err_count),
        .o_pending  (pending),
        .o_granted  (granted),
        .o_released (released),
        .o_nomem    (nomem_cnt),
        .o_inval    (inval_cnt),
        .o_zero     (zero_cnt)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 10);
    end

    // granted handles come back on the result channel; any nonzero data_chunk is one
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready && m_axis_tdata != 0)
            live_handles.push_back(m_axis_tdata);
    end

    task automatic send_beat(input t_func op, input logic [REQ_BYTES_W-1:0] nbytes,
                             input logic [CHUNK_IDX_W-1:0] idx);
        while (!steady && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {idx, nbytes};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int                     pick;
        int                     k;
        logic [REQ_BYTES_W-1:0] sz;
        logic [CHUNK_IDX_W-1:0] h;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: edge sizes, full pool, holes, bad and double frees
        send_beat(FUNC_ALLOC, 32'd0, 8'd0);
        send_beat(FUNC_ALLOC, 32'd16385, 8'd0);
        send_beat(FUNC_ALLOC, 32'hFFFF_FFFF, 8'd0);
        send_beat(FUNC_ALLOC, 32'd16384, 8'd0);     // needs one more chunk than the pool
        send_beat(FUNC_ALLOC, 32'd16320, 8'd0);     // exactly the whole pool
        send_beat(FUNC_ALLOC, 32'd1, 8'd0);
        send_beat(FUNC_FREE, 32'd0, 8'd1);
        send_beat(FUNC_FREE, 32'd0, 8'd1);          // double free
        send_beat(FUNC_FREE, 32'd0, 8'd0);
        send_beat(FUNC_FREE, 32'd0, 8'd255);
        send_beat(FUNC_ALLOC, 32'd1, 8'd0);
        send_beat(FUNC_ALLOC, 32'd64, 8'hFF);
        send_beat(FUNC_ALLOC, 32'd65, 8'd0);
        send_beat(FUNC_FREE, 32'd0, 8'd3);
        send_beat(FUNC_ALLOC, 32'd100, 8'd0);       // too big for the hole
        send_beat(FUNC_ALLOC, 32'd30, 8'd0);        // refills the hole
        send_beat(FUNC_FREE, 32'd0, 8'd2);          // points into a run, not at its start
        send_beat(FUNC_ALLOC, 32'd15680, 8'd0);     // ends on the last chunk
        send_beat(FUNC_FREE, 32'd0, 8'd11);
        send_beat(FUNC_FREE, 32'hFFFF_FFFF, 8'd1);
        send_beat(FUNC_FREE, 32'd0, 8'd3);
        send_beat(FUNC_FREE, 32'd0, 8'd5);
        send_beat(FUNC_FREE, 32'd0, 8'd8);
        drain_results();
        live_handles.delete();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 300 && n < 450);
            if (n == 200 || n == 550)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                case ($urandom_range(0, 3))
                    0: send_beat(FUNC_ALLOC, $urandom, CHUNK_IDX_W'($urandom_range(0, 255)));
                    1: send_beat(FUNC_ALLOC, 32'd0, CHUNK_IDX_W'($urandom_range(0, 255)));
                    2: send_beat(FUNC_FREE, $urandom, CHUNK_IDX_W'($urandom_range(0, 255)));
                    default: begin
                        if (freed_handles.size() != 0)
                            h = freed_handles[$urandom_range(0, freed_handles.size() - 1)];
                        else
                            h = '0;
                        send_beat(FUNC_FREE, $urandom, h);
                    end
                endcase
            end else if (live_handles.size() == 0 || pick < 55) begin
                if ($urandom_range(0, 9) == 0)
                    sz = $urandom_range(1025, 16384);
                else
                    sz = $urandom_range(1, 1024);
                send_beat(FUNC_ALLOC, sz, CHUNK_IDX_W'($urandom_range(0, 255)));
            end else begin
                k = $urandom_range(0, live_handles.size() - 1);
                h = live_handles[k];
                live_handles.delete(k);
                freed_handles.push_back(h);
                if (freed_handles.size() > 32)
                    void'(freed_handles.pop_front());
                send_beat(FUNC_FREE, $urandom, h);
            end
        end
        steady = 1'b0;
        drain_results();
        repeat (20) @(posedge i_clk);

        $display("covered: %0d allocations granted, %0d frees accepted, %0d out of memory",
                 granted, released, nomem_cnt);
        $display("         %0d invalid frees, %0d zero-size requests", inval_cnt, zero_cnt);
        if (err_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
src/ffca_pkg.sv
src/ffca_chunk_mem.sv
src/ffca_fit_unit.sv
src/ffca_ctrl.sv
src/first_fit_chunk_allocator.sv
test/ffca_result_check.sv
test/tb_top.sv
